FILE: rtl/rse_pkg.sv
// ----------------------------------------------------------------------------
// Randomized set engine package
// Shared types, codes and sizing constants for the randomized set engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_BITS       = 32;
   localparam int RANDOM_BITS      = 31;
   localparam int COUNT_OUT_BITS   = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SAMPLE = 2'd2
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_PRESENCE = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DIV,
      S_SMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [VALUE_BITS-1:0]  value;
      logic [RANDOM_BITS-1:0]        random_word;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic signed [VALUE_BITS-1:0]  sample_value;
      logic [COUNT_OUT_BITS-1:0]     element_count;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/rse_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rse_mod.sv
// ----------------------------------------------------------------------------
// Randomized set engine remainder unit
// Restoring radix-2 remainder of the random word by the element count,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rse_mod
   import rse_pkg::*;
#(
   parameter int CW = 7
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [RANDOM_BITS-1:0] dividend,
   input  wire logic [CW-1:0]          divisor,
   output logic                        done,
   output logic      [CW-1:0]          remainder
);

   localparam int IW = $clog2(RANDOM_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [IW-1:0]          iter_ff, iter_in;
   logic [RANDOM_BITS-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]          dsr_ff, dsr_in;
   logic [CW-1:0]          rem_ff, rem_in;
   logic [CW:0]            trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      trial   = {rem_ff, dvd_ff[RANDOM_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = IW'(RANDOM_BITS);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[RANDOM_BITS-2:0], 1'b0};
         iter_in = iter_ff - 1'b1;
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = CW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[CW-1:0];
         end
         if (iter_ff == IW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/randomized_set_engine_unit.sv
// Insert and remove scan one stored entry per cycle until a match or the end of the set.
// A sample on a non-empty set waits for the 31-step remainder unit and then one memory read.
// One word is handled at a time; the next is accepted once the result is registered.
// Reset is synchronous and active high; it empties the set and the memory is not cleared.
// ----------------------------------------------------------------------------
// Randomized set engine
// Holds a set of distinct values in a dense memory with an element count and
// serves insert, remove and random sample operations.
// ----------------------------------------------------------------------------
`default_nettype none

module randomized_set_engine_unit
   import rse_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type       state_ff, state_in;
   req_word_type    op_ff, op_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [AW-1:0]   slot_ff, slot_in;
   status_type      res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_sample_ff, res_sample_in;
   rsp_word_type    rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic                  rd_en, wr_en;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic [VALUE_BITS-1:0] wr_data, rd_data;
   logic                  div_start;
   logic                  div_done;
   logic [CW-1:0]         div_rem;
   logic [CW-1:0]         last_idx;
   logic                  req_take;

   rse_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rse_mod #(
      .CW (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_word.random_word),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_sample_ff <= res_sample_in;
      rsp_ff        <= rsp_in;
   end

   assign req_take = req_valid && (state_ff == S_IDLE);
   assign last_idx = count_ff - 1'b1;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      slot_in        = slot_ff;
      res_status_in  = res_status_ff;
      res_sample_in  = res_sample_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      wr_data        = op_ff.value;
      div_start      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in         = req_word;
               idx_in        = '0;
               res_sample_in = '0;
               case (req_word.kind)
                  OP_INSERT, OP_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  OP_SAMPLE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_FINISH;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                     res_status_in = ST_PRESENCE;
                     state_in      = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff && (rd_data == op_ff.value)) begin
               if (op_ff.kind == OP_INSERT) begin
                  res_status_in = ST_PRESENCE;
                  state_in      = S_FINISH;
               end else if (cmp_idx_ff == last_idx[AW-1:0]) begin
                  count_in      = last_idx;
                  res_status_in = ST_OK;
                  state_in      = S_FINISH;
               end else begin
                  slot_in  = cmp_idx_ff;
                  state_in = S_MOVE_RD;
               end
            end else if (idx_ff < count_ff) begin
               rd_en      = 1'b1;
               pend_in    = 1'b1;
               cmp_idx_in = idx_ff[AW-1:0];
               idx_in     = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = S_FINISH;
               if (op_ff.kind != OP_INSERT) begin
                  res_status_in = ST_PRESENCE;
               end else if (count_ff >= CW'(CAPACITY)) begin
                  res_status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = ST_OK;
               end
            end
         end
         S_MOVE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = last_idx[AW-1:0];
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            wr_en         = 1'b1;
            wr_addr       = slot_ff;
            wr_data       = rd_data;
            count_in      = last_idx;
            res_status_in = ST_OK;
            state_in      = S_FINISH;
         end
         S_DIV: begin
            if (div_done) begin
               rd_en    = 1'b1;
               rd_addr  = div_rem[AW-1:0];
               state_in = S_SMP;
            end
         end
         S_SMP: begin
            res_sample_in = rd_data;
            res_status_in = ST_OK;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status        = res_status_ff;
               rsp_in.sample_value  = res_sample_ff;
               rsp_in.element_count = COUNT_OUT_BITS'(count_ff);
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |->
         (count_ff == CW'($past(count_ff) + 1'b1)) ||
         (count_ff == CW'($past(count_ff) - 1'b1)))
      else $error("element count moved by more than one");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("remainder finished outside the sample wait");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCAN) || (state_ff == S_MOVE_WR))
      else $error("memory write outside insert or remove");
`endif

endmodule

`default_nettype wire
